// ----- rtl/tlpq_pkg.sv -----
// Package for the two-level preemptive queue scheduler: word formats,
// table entry layout, queue control structs and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlpq_pkg;

    localparam int MAX_TASKS_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int TASK_ID_W = 6;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 32;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [TASK_ID_W-1:0] task_id;
        logic [BURST_W-1:0]   burst_len;
        logic                 is_user;
    } t_in_word;

    typedef struct packed {
        logic [TASK_ID_W-1:0] run_id;
        logic                 busy_res;
        logic                 finished;
        logic [TIME_W-1:0]    finish_time;
        logic [TIME_W-1:0]    turnaround;
        logic [TIME_W-1:0]    waiting;
    } t_out_word;

    // one task table entry, indexed by task id
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remain;
        logic [TIME_W-1:0]  arrival;
        logic               is_user;
    } t_task_ent;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_sts;

endpackage

`default_nettype wire

// ----- rtl/tlpq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/tlpq_ring.sv -----
// FIFO ring of task ids: head pointer, fill count and one RAM for the slots.
// Depends on tlpq_pkg and tlpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module tlpq_ring
    import tlpq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_W  = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_ring_ctl       i_ctl,
    input  wire logic [ID_W-1:0] i_push_id,
    output logic      [ID_W-1:0] o_head_id,
    output t_ring_sts            o_sts
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0]   DEPTH_V   = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW:0]   r_count, n_count;
    logic [AW:0]   w_tail_sum;
    logic [AW:0]   w_tail_wrap;
    logic [AW-1:0] w_tail;
    logic          w_full, w_empty;
    logic          w_push, w_pop;

    assign w_full  = (r_count == DEPTH_V);
    assign w_empty = (r_count == '0);
    assign w_push  = i_ctl.push && !w_full;
    assign w_pop   = i_ctl.pop && !w_empty;

    // head + count stays below twice the depth: one compare and subtract wraps it
    assign w_tail_sum  = {1'b0, r_head} + r_count;
    assign w_tail_wrap = (w_tail_sum >= DEPTH_V) ? (w_tail_sum - DEPTH_V) : w_tail_sum;
    assign w_tail      = w_tail_wrap[AW-1:0];

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (w_pop) begin
            n_head = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + (AW+1)'(1);
            2'b01:   n_count = r_count - (AW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    tlpq_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (w_tail),
        .i_wr_data (i_push_id),
        .i_rd_en   (i_ctl.rd),
        .i_rd_addr (r_head),
        .o_rd_data (o_head_id)
    );

    assign o_sts.empty = w_empty;
    assign o_sts.full  = w_full;

endmodule

`default_nettype wire

// ----- rtl/two_level_preemptive_queue_scheduler.sv -----
// Top level of the two-level preemptive queue scheduler: sequencer, task
// table RAM, shared subtractor and output register.
// Depends on tlpq_pkg, tlpq_ram and tlpq_ring.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------
//  in      | input     | i_in_valid / o_in_stall   | t_in_word
//  out     | output    | o_out_valid / i_out_stall | t_out_word
//
// An arrival word is taken in the idle state. A tick word visits decide and
// output with no task, also fetch and execute with one, and also turnaround
// and waiting when it completes: the task table RAM is read twice (decide,
// then fetch); one subtractor does decrement, turnaround, waiting in turn.
// Reset clears the queue pointers, the tick count and the running task;
// tables hold garbage until written, with no clearing pass.
// A stalled output holds its word; the next word is still accepted, and a
// tick waits in its final state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module two_level_preemptive_queue_scheduler
    import tlpq_pkg::*;
#(
    parameter int MAX_TASKS   = MAX_TASKS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int TW = $clog2(MAX_TASKS);
    localparam logic [TASK_ID_W+TW:0] MAX_TASKS_V = (TASK_ID_W+TW+1)'(MAX_TASKS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_EXEC   = 7'b0001000,
        S_TAT    = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [TW-1:0]      r_cur, n_cur;
    logic               r_cur_valid, n_cur_valid;
    logic [TIME_W-1:0]  r_tick, n_tick;
    logic [TIME_W-1:0]  r_arr, n_arr;
    logic [BURST_W-1:0] r_burst, n_burst;
    t_out_word          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic                    w_acc;
    logic [TASK_ID_W+TW-1:0] w_tid_ext;
    logic [TW-1:0]           w_tid_idx;
    logic                    w_tid_ok;
    logic [TASK_ID_W+TW-1:0] w_cur_ext;
    logic [TASK_ID_W-1:0]    w_run_id;
    logic [BURST_W-1:0]      w_burst_eff;
    logic                    w_preempt;
    logic [BURST_W-1:0]      w_rem_n;

    t_ring_ctl     w_sys_ctl, w_usr_ctl;
    t_ring_sts     w_sys_sts, w_usr_sts;
    logic [TW-1:0] w_sys_head, w_usr_head;
    logic [TW-1:0] w_usr_push_id;

    logic          w_task_we, w_task_re;
    logic [TW-1:0] w_task_waddr;
    t_task_ent     w_task_wdata;
    t_task_ent     w_task_rd;

    logic [TIME_W-1:0] w_sub_a, w_sub_b, w_sub_d;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;

    // widen before selecting so any table depth works with a 6-bit id
    assign w_tid_ext   = {{TW{1'b0}}, i_in_word.task_id};
    assign w_tid_idx   = w_tid_ext[TW-1:0];
    assign w_tid_ok    = ({1'b0, w_tid_ext} < MAX_TASKS_V);
    assign w_cur_ext   = {{TASK_ID_W{1'b0}}, r_cur};
    assign w_run_id    = w_cur_ext[TASK_ID_W-1:0];
    assign w_burst_eff = (i_in_word.burst_len == '0) ? BURST_W'(1) : i_in_word.burst_len;

    assign w_preempt = r_cur_valid && w_task_rd.is_user && !w_sys_sts.empty
                       && !w_usr_sts.full;

    // shared subtractor
    always_comb begin
        w_sub_a = '0;
        w_sub_b = '0;
        case (r_state)
            S_EXEC: begin
                w_sub_a = {{(TIME_W-BURST_W){1'b0}}, w_task_rd.remain};
                w_sub_b = TIME_W'(1);
            end
            S_TAT: begin
                w_sub_a = r_tick;
                w_sub_b = r_arr;
            end
            S_WAIT: begin
                w_sub_a = r_res.turnaround;
                w_sub_b = {{(TIME_W-BURST_W){1'b0}}, r_burst};
            end
            default: begin
                w_sub_a = '0;
                w_sub_b = '0;
            end
        endcase
    end

    assign w_sub_d = w_sub_a - w_sub_b;
    // saturate at zero: a task with nothing left still completes
    assign w_rem_n = (w_task_rd.remain == '0) ? '0 : w_sub_d[BURST_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_cur         = r_cur;
        n_cur_valid   = r_cur_valid;
        n_tick        = r_tick;
        n_arr         = r_arr;
        n_burst       = r_burst;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_word    = r_out_word;
        w_sys_ctl     = '0;
        w_usr_ctl     = '0;
        w_usr_push_id = r_cur;
        w_task_we     = 1'b0;
        w_task_re     = 1'b0;
        w_task_waddr  = r_cur;
        w_task_wdata  = w_task_rd;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in_word.op == OP_TICK) begin
                        w_sys_ctl.rd = 1'b1;
                        w_usr_ctl.rd = 1'b1;
                        w_task_re    = 1'b1;
                        n_state      = S_DECIDE;
                    end else if (w_tid_ok) begin
                        w_task_we    = 1'b1;
                        w_task_waddr = w_tid_idx;
                        w_task_wdata = '{burst:   w_burst_eff,
                                         remain:  w_burst_eff,
                                         arrival: r_tick,
                                         is_user: i_in_word.is_user};
                        w_usr_push_id = w_tid_idx;
                        if (i_in_word.is_user) begin
                            w_usr_ctl.push = 1'b1;
                        end else begin
                            w_sys_ctl.push = 1'b1;
                        end
                    end
                end
            end
            S_DECIDE: begin
                n_res = '0;
                // requeue a user task at the tail when a system task waits and the user queue has room
                w_usr_ctl.push = w_preempt;
                if (r_cur_valid && !w_preempt) begin
                    n_state = S_FETCH;
                end else if (!w_sys_sts.empty) begin
                    w_sys_ctl.pop = 1'b1;
                    n_cur         = w_sys_head;
                    n_cur_valid   = 1'b1;
                    n_state       = S_FETCH;
                end else if (!w_usr_sts.empty) begin
                    w_usr_ctl.pop = 1'b1;
                    n_cur         = w_usr_head;
                    n_cur_valid   = 1'b1;
                    n_state       = S_FETCH;
                end else begin
                    n_cur_valid = 1'b0;
                    n_tick      = r_tick + TIME_W'(1);
                    n_state     = S_OUT;
                end
            end
            S_FETCH: begin
                w_task_re = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                n_arr               = w_task_rd.arrival;
                n_burst             = w_task_rd.burst;
                w_task_we           = 1'b1;
                w_task_wdata.remain = w_rem_n;
                n_tick              = r_tick + TIME_W'(1);
                n_res.run_id        = w_run_id;
                n_res.busy_res      = 1'b1;
                if (w_rem_n == '0) begin
                    n_res.finished    = 1'b1;
                    n_res.finish_time = r_tick + TIME_W'(1);
                    n_cur_valid       = 1'b0;
                    n_state           = S_TAT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TAT: begin
                n_res.turnaround = w_sub_d;
                n_state          = S_WAIT;
            end
            S_WAIT: begin
                n_res.waiting = w_sub_d;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arr      <= n_arr;
        r_burst    <= n_burst;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    tlpq_ring #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (TW)
    ) u_sys_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_sys_ctl),
        .i_push_id (w_tid_idx),
        .o_head_id (w_sys_head),
        .o_sts     (w_sys_sts)
    );

    tlpq_ring #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (TW)
    ) u_usr_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_usr_ctl),
        .i_push_id (w_usr_push_id),
        .o_head_id (w_usr_head),
        .o_sts     (w_usr_sts)
    );

    tlpq_ram #(
        .WIDTH ($bits(t_task_ent)),
        .DEPTH (MAX_TASKS)
    ) u_task_tab (
        .i_clk     (i_clk),
        .i_wr_en   (w_task_we),
        .i_wr_addr (w_task_waddr),
        .i_wr_data (w_task_wdata),
        .i_rd_en   (w_task_re),
        .i_rd_addr (r_cur),
        .o_rd_data (w_task_rd)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ----- rtl/tlpq_chk.sv -----
// Port-level checker for the scheduler top level, bound to it below.
// Depends on tlpq_pkg and two_level_preemptive_queue_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module tlpq_chk
    import tlpq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // hold a stalled result
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // an arrival word leaves the sequencer idle
    a_arrive_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.op == OP_ARRIVE) |=> !o_in_stall)
        else $error("input stalled after an arrival");

    // a tick word occupies the sequencer
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.op == OP_TICK) |=> o_in_stall)
        else $error("input not stalled after a tick");

    // an idle tick reports no task and no completion
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.busy_res |->
            (o_out_word.run_id == '0) && !o_out_word.finished)
        else $error("idle tick result carries a task");

endmodule

bind two_level_preemptive_queue_scheduler tlpq_chk u_tlpq_chk (.*);

`default_nettype wire

// ----- sim/tlpq_sched_checker.sv -----
// Scoreboard for the two-level preemptive queue scheduler: follows both
// channels, keeps its own model of the queues and task tables, checks each tick word.
// Depends on tlpq_pkg.
`timescale 1ns / 1ps

module tlpq_sched_checker
    import tlpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam bit CLS_SYS  = 1'b0;
    localparam bit CLS_USER = 1'b1;

    // ready queues, indexed by class (system, user)
    logic [TASK_ID_W-1:0] queued_ids [2][QUEUE_DEPTH_DEF];
    int                   queue_rd   [2];
    int                   queue_fill [2];

    // per-task tables
    logic [BURST_W-1:0] units_needed [MAX_TASKS_DEF];
    logic [BURST_W-1:0] units_left   [MAX_TASKS_DEF];
    logic [TIME_W-1:0]  arrived_at   [MAX_TASKS_DEF];
    logic               task_is_user [MAX_TASKS_DEF];

    logic [TASK_ID_W-1:0] run_task;
    logic                 run_live;
    logic [TIME_W-1:0]    tick_now;

    t_out_word tick_reports [$];
    int        fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit enqueue(input bit cls, input logic [TASK_ID_W-1:0] id);
        if (queue_fill[cls] >= QUEUE_DEPTH_DEF)
            return 1'b0;
        queued_ids[cls][(queue_rd[cls] + queue_fill[cls]) % QUEUE_DEPTH_DEF] = id;
        queue_fill[cls]++;
        return 1'b1;
    endfunction

    function automatic logic [TASK_ID_W-1:0] dequeue(input bit cls);
        logic [TASK_ID_W-1:0] id;
        id = queued_ids[cls][queue_rd[cls]];
        queue_rd[cls] = (queue_rd[cls] + 1) % QUEUE_DEPTH_DEF;
        queue_fill[cls]--;
        return id;
    endfunction

    task automatic log_arrival(input t_in_word w);
        logic [BURST_W-1:0] need;
        need = (w.burst_len == '0) ? BURST_W'(1) : w.burst_len;
        units_needed[w.task_id] = need;
        units_left[w.task_id]   = need;
        arrived_at[w.task_id]   = tick_now;
        task_is_user[w.task_id] = w.is_user;
        // a full queue drops the id but keeps the table write
        void'(enqueue(w.is_user, w.task_id));
    endtask

    task automatic advance_tick(output t_out_word r);
        logic [BURST_W-1:0] left;
        r = '0;
        // preempt a user task when system work waits, unless the user queue is full
        if (run_live && task_is_user[run_task] == CLS_USER && queue_fill[CLS_SYS] != 0) begin
            if (enqueue(CLS_USER, run_task))
                run_live = 1'b0;
        end
        if (!run_live) begin
            if (queue_fill[CLS_SYS] != 0) begin
                run_task = dequeue(CLS_SYS);
                run_live = 1'b1;
            end else if (queue_fill[CLS_USER] != 0) begin
                run_task = dequeue(CLS_USER);
                run_live = 1'b1;
            end
        end
        if (!run_live) begin
            tick_now++;
        end else begin
            left = (units_left[run_task] != '0) ? units_left[run_task] - 1'b1 : '0;
            units_left[run_task] = left;
            tick_now++;
            r.run_id   = run_task;
            r.busy_res = 1'b1;
            if (left == '0) begin
                r.finished    = 1'b1;
                r.finish_time = tick_now;
                r.turnaround  = tick_now - arrived_at[run_task];
                r.waiting     = r.turnaround - TIME_W'(units_needed[run_task]);
                run_live      = 1'b0;
            end
        end
    endtask

    task automatic compare(input string name, input logic [TIME_W-1:0] want,
                           input logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            queue_rd   = '{0, 0};
            queue_fill = '{0, 0};
            run_task   = '0;
            run_live   = 1'b0;
            tick_now   = '0;
            tick_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (tick_reports.size() == 0) begin
                    $error("result word with nothing expected: run_id %0d busy %0d",
                           i_out_word.run_id, i_out_word.busy_res);
                    fails++;
                end else begin
                    want = tick_reports.pop_front();
                    compare("run_id", TIME_W'(want.run_id), TIME_W'(i_out_word.run_id));
                    compare("busy_res", TIME_W'(want.busy_res),
                            TIME_W'(i_out_word.busy_res));
                    compare("finished", TIME_W'(want.finished),
                            TIME_W'(i_out_word.finished));
                    compare("finish_time", want.finish_time, i_out_word.finish_time);
                    compare("turnaround",  want.turnaround,  i_out_word.turnaround);
                    compare("waiting",     want.waiting,     i_out_word.waiting);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_word.op == OP_TICK) begin
                    advance_tick(want);
                    tick_reports.push_back(want);
                end else begin
                    log_arrival(i_in_word);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= tick_reports.size();
    end

endmodule

// ----- sim/tb_two_level_preemptive_queue_scheduler.sv -----
// Testbench top for the two-level preemptive queue scheduler: clock, reset,
// arrival and tick stimulus, output back-pressure and the verdict.
// Depends on tlpq_pkg, the scheduler RTL and tlpq_sched_checker.
`timescale 1ns / 1ps

module tb_two_level_preemptive_queue_scheduler;
    import tlpq_pkg::*;

    localparam int WORDS_WANTED = 950;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    int fail_count;
    int pending;
    int words_sent = 0;
    bit quiet      = 1'b0;

    always #1 clk = ~clk;

    two_level_preemptive_queue_scheduler DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    tlpq_sched_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk)
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 30);

    // hold the word until the scheduler takes it
    task automatic send_word(input t_in_word w);
        while (!quiet && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        quiet <= (words_sent >= 300 && words_sent < 500);
    endtask

    task automatic arrive(input logic [TASK_ID_W-1:0] id, input logic [BURST_W-1:0] burst,
                          input logic user);
        t_in_word w;
        w           = '0;
        w.op        = OP_ARRIVE;
        w.task_id   = id;
        w.burst_len = burst;
        w.is_user   = user;
        send_word(w);
    endtask

    // random payload bits in the unused fields of a tick
    task automatic tick();
        t_in_word w;
        w    = t_in_word'({$urandom, $urandom});
        w.op = OP_TICK;
        send_word(w);
    endtask

    function automatic logic [BURST_W-1:0] pick_burst(input logic user);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 80)
            return BURST_W'($urandom_range(1, 3));
        if (r < 98 || !user)
            return BURST_W'($urandom_range(4, 16));
        // long user job, kept alive only by preemption slicing
        return BURST_W'($urandom);
    endfunction

    initial begin : stimulus
        int   pick;
        logic cls;
        logic user;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, then zero burst on the top id
        tick();
        arrive(6'd63, 16'd0, 1'b0);
        tick();
        // same id queued twice: the second run starts with nothing left
        arrive(6'd0, 16'd1, 1'b0);
        arrive(6'd0, 16'd1, 1'b0);
        tick();
        tick();
        // user task preempted by a system arrival, then overwritten while queued
        arrive(6'd10, 16'd3, 1'b1);
        tick();
        arrive(6'd20, 16'd2, 1'b0);
        tick();
        arrive(6'd10, 16'd2, 1'b1);
        tick();
        tick();
        arrive(6'd33, 16'hFFFF, 1'b1);
        repeat (5) tick();

        while (words_sent < WORDS_WANTED) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                // flood one class past its queue depth behind a running task
                cls = 1'($urandom_range(1));
                arrive(TASK_ID_W'($urandom), pick_burst(1'b1), 1'b1);
                tick();
                repeat ($urandom_range(66, 70))
                    arrive(TASK_ID_W'($urandom), BURST_W'($urandom_range(1, 3)), cls);
                arrive(TASK_ID_W'($urandom), BURST_W'($urandom_range(1, 3)), 1'b0);
                repeat (3) tick();
            end else if (pick < 25) begin
                repeat ($urandom_range(5, 20)) tick();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    user = 1'($urandom_range(1));
                    arrive(TASK_ID_W'($urandom), pick_burst(user), user);
                end
                repeat ($urandom_range(2, 12)) tick();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
